// File: rtl/gsat_pkg.sv
// Package for the supplier revenue group-by block: transaction payload types
// and fixed field widths shared by the top level and its testbench.
// No dependencies.
`default_nettype none

package gsat_pkg;

	localparam int DATE_W = 32;
	localparam int WH_W   = 12;
	localparam int ITEM_W = 17;
	localparam int AMT_W  = 20;
	localparam int SUP_W  = 14;
	localparam int REV_W  = 48;
	localparam int CNT_W  = 32;
	localparam int PROD_W = WH_W + ITEM_W;

	localparam logic [REV_W-1:0] REV_MAX = {REV_W{1'b1}};
	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	localparam logic FUNC_ADD    = 1'b0;
	localparam logic FUNC_FINISH = 1'b1;

	typedef struct packed {
		logic              func;
		logic [DATE_W-1:0] delivery_date;
		logic [WH_W-1:0]   supply_warehouse;
		logic [ITEM_W-1:0] item_number;
		logic [AMT_W-1:0]  line_amount;
	} item_t;

	typedef struct packed {
		logic [SUP_W-1:0] supplier_number;
		logic [REV_W-1:0] peak_revenue;
		logic             found;
		logic             last;
		logic             ties_overflow;
		logic [CNT_W-1:0] rows_selected;
	} result_t;

endpackage

`default_nettype wire

// File: rtl/gsat_ram.sv
// Generic single-clock RAM: one write port, one read port with registered
// read data and read enable. Read during write to the same entry returns old data.
`default_nettype none

module gsat_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                       clk,
	input  wire logic                       we,
	input  wire logic [$clog2(DEPTH)-1:0]   waddr,
	input  wire logic [WIDTH-1:0]           wdata,
	input  wire logic                       re,
	input  wire logic [$clog2(DEPTH)-1:0]   raddr,
	output logic      [WIDTH-1:0]           rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// File: rtl/group_sum_argmax_ties_top.sv
// Top level of the supplier revenue group-by with argmax and ties.
// Depends on gsat_pkg (payload types, widths) and gsat_ram (bucket store).
//
// Usage:
//  item channel (item_valid/item_ready/item): an add transaction maps its
//  line to supplier (warehouse * item) mod NUM_SUPPLIERS + 1 and adds the
//  amount to that bucket; a zero delivery date is dropped. Adds are taken one
//  per cycle while item_ready is high and produce no result; a four-stage
//  pipeline (product, reciprocal multiply, remainder, bucket read-modify-write
//  with forwarding) carries them. A finish transaction drains that pipeline,
//  scans all NUM_SUPPLIERS buckets for the maximum, then scans again emitting
//  ties in ascending order while writing every bucket back to zero. Each scan
//  reads the buckets in turn through the single read port of the bucket RAM.
//  item_ready is low during a finish.
//  result channel (result_valid/result_ready/result): one output register;
//  a stalled receiver holds the emit scan on the matching bucket. With nothing
//  present one not-found result with last set is sent.
//  Reset: the bucket RAM is swept to zero, one entry a cycle, with item_ready
//  low; the row count clears at once.
`default_nettype none

module group_sum_argmax_ties_top
	import gsat_pkg::*;
#(
	parameter int NUM_SUPPLIERS = 10000,
	parameter int MAX_TIES      = 64
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    item_valid,
	output logic         item_ready,
	input  wire item_t   item,
	output logic         result_valid,
	input  wire logic    result_ready,
	output result_t      result
);

	localparam int AW = $clog2(NUM_SUPPLIERS);
	localparam int CW = AW + 1;
	localparam int TW = $clog2(MAX_TIES + 2);
	localparam int DW = REV_W + 1;
	localparam int PW = PROD_W;
	localparam int MW = 2 * PW;

	localparam logic [PW-1:0] RECIP    = PW'((64'd1 << PW) / NUM_SUPPLIERS);
	localparam logic [PW-1:0] NUM_P    = PW'(NUM_SUPPLIERS);
	localparam logic [CW-1:0] NUM_C    = CW'(NUM_SUPPLIERS);
	localparam logic [CW-1:0] LAST_C   = CW'(NUM_SUPPLIERS - 1);
	localparam logic [TW-1:0] TIES_LIM = TW'(MAX_TIES);
	localparam logic [TW-1:0] TIES_SAT = TW'(MAX_TIES + 1);

	typedef enum logic [5:0] {
		ST_INIT  = 6'b000001,
		ST_IDLE  = 6'b000010,
		ST_DRAIN = 6'b000100,
		ST_MAX   = 6'b001000,
		ST_EMIT  = 6'b010000,
		ST_NONE  = 6'b100000
	} state_t;

	state_t state_q;

	// add pipeline
	logic              v_s1, v_s2, v_s3, v_s4;
	logic [PW-1:0]     p_s1, p_s2;
	logic [PW-1:0]     q_s2;
	logic [AMT_W-1:0]  amt_s1, amt_s2, amt_s3, amt_s4;
	logic [AW-1:0]     idx_s3, idx_s4;
	logic              fwd_v_q;
	logic [AW-1:0]     fwd_idx_q;
	logic [REV_W-1:0]  fwd_rev_q;

	logic [CNT_W-1:0]  row_q;

	// scans
	logic [CW-1:0]     scan_q;
	logic              dv_q;
	logic [AW-1:0]     di_q;
	logic [REV_W-1:0]  best_q;
	logic              any_q;
	logic [TW-1:0]     ties_q;
	logic [TW-1:0]     emit_q;

	result_t           out_q;
	logic              out_v_q;

	// RAM ports
	logic              ram_we, ram_re;
	logic [AW-1:0]     ram_waddr, ram_raddr;
	logic [DW-1:0]     ram_wdata, ram_rdata;

	logic              acc, add_acc, fin_acc;
	logic [MW-1:0]     recip_prod;
	logic [PW-1:0]     qn, rem, rem_fix;
	logic [REV_W-1:0]  base_rev;
	logic [DW-1:0]     sum_ext;
	logic [REV_W-1:0]  new_rev;
	logic              rd_present;
	logic [REV_W-1:0]  rd_rev;
	logic              issue;
	logic [TW-1:0]     limit;
	logic              ovf;
	logic              hit, stall, adv;
	logic              out_free;
	logic              pipe_busy;
	logic [SUP_W:0]    sup_full;

	assign item_ready = (state_q == ST_IDLE);
	assign acc        = item_valid && item_ready;
	assign add_acc    = acc && (item.func == FUNC_ADD) && (item.delivery_date != '0);
	assign fin_acc    = acc && (item.func == FUNC_FINISH);

	assign recip_prod = MW'(p_s1) * MW'(RECIP);
	assign qn         = q_s2 * NUM_P;
	assign rem        = p_s2 - qn;
	// reciprocal estimate is low by at most one
	assign rem_fix    = (rem >= NUM_P) ? rem - NUM_P : rem;

	assign rd_present = ram_rdata[REV_W];
	assign rd_rev     = ram_rdata[REV_W-1:0];
	assign base_rev   = (fwd_v_q && (fwd_idx_q == idx_s4)) ? fwd_rev_q : rd_rev;
	assign sum_ext    = {1'b0, base_rev} + DW'(amt_s4);
	assign new_rev    = sum_ext[REV_W] ? REV_MAX : sum_ext[REV_W-1:0];

	assign pipe_busy  = v_s1 || v_s2 || v_s3 || v_s4;
	assign issue      = (scan_q < NUM_C);
	assign ovf        = (ties_q > TIES_LIM);
	assign limit      = ovf ? TIES_LIM : ties_q;
	assign out_free   = !out_v_q || result_ready;
	assign hit        = (state_q == ST_EMIT) && dv_q && rd_present && (rd_rev == best_q)
		&& (emit_q < limit);
	assign stall      = hit && !out_free;
	assign adv        = !stall;
	assign sup_full   = (SUP_W + 1)'(di_q) + (SUP_W + 1)'(1);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = idx_s4;
		ram_wdata = {1'b1, new_rev};
		ram_re    = 1'b0;
		ram_raddr = idx_s3;
		case (state_q)
			ST_INIT: begin
				ram_we    = 1'b1;
				ram_waddr = scan_q[AW-1:0];
				ram_wdata = '0;
			end
			ST_MAX: begin
				ram_re    = issue;
				ram_raddr = scan_q[AW-1:0];
			end
			ST_EMIT: begin
				ram_we    = adv && dv_q;
				ram_waddr = di_q;
				ram_wdata = '0;
				ram_re    = adv && issue;
				ram_raddr = scan_q[AW-1:0];
			end
			default: begin
				ram_we = v_s4;
				ram_re = v_s3;
			end
		endcase
	end

	gsat_ram #(
		.WIDTH(DW),
		.DEPTH(NUM_SUPPLIERS)
	) u_bins (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// payload registers
	always_ff @(posedge clk) begin
		p_s1   <= PW'(item.supply_warehouse) * PW'(item.item_number);
		amt_s1 <= item.line_amount;
		p_s2   <= p_s1;
		q_s2   <= recip_prod[MW-1:PW];
		amt_s2 <= amt_s1;
		idx_s3 <= rem_fix[AW-1:0];
		amt_s3 <= amt_s2;
		idx_s4 <= idx_s3;
		amt_s4 <= amt_s3;
		fwd_idx_q <= idx_s4;
		fwd_rev_q <= new_rev;
		if (hit && adv) begin
			out_q.supplier_number <= sup_full[SUP_W-1:0];
			out_q.peak_revenue    <= best_q;
			out_q.found           <= 1'b1;
			out_q.last            <= ((emit_q + TW'(1)) == limit);
			out_q.ties_overflow   <= ovf;
			out_q.rows_selected   <= row_q;
		end else if (state_q == ST_NONE && out_free) begin
			out_q.supplier_number <= '0;
			out_q.peak_revenue    <= '0;
			out_q.found           <= 1'b0;
			out_q.last            <= 1'b1;
			out_q.ties_overflow   <= 1'b0;
			out_q.rows_selected   <= row_q;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			v_s4    <= 1'b0;
			fwd_v_q <= 1'b0;
			row_q   <= '0;
			scan_q  <= '0;
			dv_q    <= 1'b0;
			di_q    <= '0;
			best_q  <= '0;
			any_q   <= 1'b0;
			ties_q  <= '0;
			emit_q  <= '0;
			out_v_q <= 1'b0;
		end else begin
			v_s1    <= add_acc;
			v_s2    <= v_s1;
			v_s3    <= v_s2;
			v_s4    <= v_s3;
			fwd_v_q <= v_s4;
			if (add_acc && row_q != CNT_MAX) begin
				row_q <= row_q + CNT_W'(1);
			end
			if (out_v_q && result_ready) begin
				out_v_q <= 1'b0;
			end
			case (state_q)
				ST_INIT: begin
					scan_q <= scan_q + CW'(1);
					if (scan_q == LAST_C) begin
						scan_q  <= '0;
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (fin_acc) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!pipe_busy) begin
						scan_q  <= '0;
						dv_q    <= 1'b0;
						best_q  <= '0;
						any_q   <= 1'b0;
						ties_q  <= '0;
						state_q <= ST_MAX;
					end
				end
				ST_MAX: begin
					dv_q <= issue;
					if (issue) begin
						scan_q <= scan_q + CW'(1);
					end
					if (dv_q && rd_present) begin
						if (!any_q || rd_rev > best_q) begin
							best_q <= rd_rev;
							ties_q <= TW'(1);
							any_q  <= 1'b1;
						end else if (rd_rev == best_q && ties_q != TIES_SAT) begin
							ties_q <= ties_q + TW'(1);
						end
					end
					if (!issue && !dv_q) begin
						scan_q  <= '0;
						emit_q  <= '0;
						state_q <= any_q ? ST_EMIT : ST_NONE;
					end
				end
				ST_EMIT: begin
					if (adv) begin
						dv_q <= issue;
						di_q <= scan_q[AW-1:0];
						if (issue) begin
							scan_q <= scan_q + CW'(1);
						end
						if (hit) begin
							out_v_q <= 1'b1;
							emit_q  <= emit_q + TW'(1);
						end
						if (!issue && !dv_q) begin
							row_q   <= '0;
							scan_q  <= '0;
							state_q <= ST_IDLE;
						end
					end
				end
				ST_NONE: begin
					// buckets are already zero when none is present
					if (out_free) begin
						out_v_q <= 1'b1;
						row_q   <= '0;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_INIT;
				end
			endcase
		end
	end

	assign result_valid = out_v_q;
	assign result       = out_q;

	a_add_write_outside_scan : assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 |-> (state_q == ST_IDLE || state_q == ST_DRAIN))
		else $error("bucket update collides with a scan");

	a_emit_within_limit : assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> (emit_q <= limit))
		else $error("more ties emitted than the limit");

	a_not_found_is_last : assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result.found) |-> (result.last && !result.ties_overflow))
		else $error("not-found result without last");

	a_scan_done_clears_rows : assert property (@(posedge clk) disable iff (!arst_n)
		($past(state_q) == ST_EMIT && state_q == ST_IDLE) |-> (row_q == '0))
		else $error("row count kept after finish");

endmodule

`default_nettype wire
